@@ design/sld_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sync/length/XOR deframer.
package sld_pkg;

    localparam logic [7:0] SYNC0         = 8'h55;
    localparam logic [7:0] SYNC1         = 8'h4E;
    localparam logic [7:0] SYNC2         = 8'h45;
    localparam logic [7:0] SYNC3         = 8'h52;
    localparam logic [7:0] TOKEN         = 8'h3A;
    localparam logic [7:0] TIMEOUT_RESET = 8'd5;
    localparam logic [7:0] HDR_XOR       = SYNC0 ^ SYNC1 ^ SYNC2 ^ SYNC3 ^ TOKEN;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_GOOD    = 2'd1,
        ST_BAD     = 2'd2,
        ST_ABORT   = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_SYNC1   = 7'b0000010,
        PH_SYNC2   = 7'b0000100,
        PH_SYNC3   = 7'b0001000,
        PH_LENGTH  = 7'b0010000,
        PH_TOKEN   = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        status_t    frame_status;
        logic       end_of_frame;
    } result_t;

endpackage

@@ design/sld_item_if.sv @@
`timescale 1ns / 1ps
// Input item channel: received bytes and timer ticks.
interface sld_item_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] rx_byte;

    modport source (output valid, output item_kind, output rx_byte, input ready);
    modport sink (input valid, input item_kind, input rx_byte, output ready);
endinterface

@@ design/sld_result_if.sv @@
`timescale 1ns / 1ps
// Result channel: payload bytes and frame end status.
interface sld_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [1:0] frame_status;
    logic       end_of_frame;

    modport source (output valid, output payload_byte, output byte_index,
                    output frame_status, output end_of_frame, input ready);
    modport sink (input valid, input payload_byte, input byte_index,
                  input frame_status, input end_of_frame, output ready);
endinterface

@@ design/sld_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel for the timeout register.
interface sld_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/sync_length_xor_deframer_core.sv @@
`timescale 1ns / 1ps
// Top level of the sync/length/XOR deframer.
// Takes one item (received byte or timer tick) per clock while the output is
// not stalled and gives at most one result per item. Each item goes through an
// input register, then the parser updates its state and writes any result into
// the output register. Throughput is one item per cycle, set by the single
// parser pass between those two registers. A stalled result register stops the
// parser and then the input. The timeout register is read only when a frame
// starts, so a write takes effect at the next frame.
module sync_length_xor_deframer_core (
    input  logic  clk,
    input  logic  rst_n,
    sld_item_if.sink     item,
    sld_result_if.source result,
    sld_cfg_if.sink      cfg
);
    import sld_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic [7:0] timeout_reg;
    logic       advance;
    logic       res_valid;
    result_t    res;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg.valid && cfg.ready)
            timeout_reg <= cfg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_item_reg <= '{item_kind: item.item_kind, rx_byte: item.rx_byte};
    end

    sld_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .timeout   (timeout_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_reg <= res;
    end

    assign result.valid        = out_valid_reg;
    assign result.payload_byte = out_reg.payload_byte;
    assign result.byte_index   = out_reg.byte_index;
    assign result.frame_status = out_reg.frame_status;
    assign result.end_of_frame = out_reg.end_of_frame;

`ifndef ASSERT_OFF
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !result.ready
        |=> in_valid_reg && $stable(in_item_reg))
        else $error("input stage lost an item during stall");

    a_result_leaves_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result register dropped or changed a pending result");
`endif

endmodule

@@ design/sld_parser.sv @@
`timescale 1ns / 1ps
// Frame parser: state registers and per-item next-state and result logic.
module sld_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  sld_pkg::item_t  item,
    input  logic [7:0]      timeout,
    output logic            res_valid,
    output sld_pkg::result_t res
);
    import sld_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] ticks_reg, ticks_next;
    logic       is_sync0;
    logic [7:0] left_dec;

    assign is_sync0 = (item.rx_byte == SYNC0);
    assign left_dec = bytes_left_reg - 8'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        count_next      = count_reg;
        ticks_next      = ticks_reg;
        res_valid       = 1'b0;
        res             = '{payload_byte: 8'd0, byte_index: 8'd0,
                            frame_status: ST_PAYLOAD, end_of_frame: 1'b0};
        if (step)
        begin
            if (item.item_kind == KIND_TICK)
            begin
                if (phase_reg != PH_HUNT)
                begin
                    if (ticks_reg > 8'd1)
                    begin
                        ticks_next = ticks_reg - 8'd1;
                    end
                    else
                    begin
                        ticks_next = 8'd0;
                        phase_next = PH_HUNT;
                        if (phase_reg == PH_PAYLOAD && count_reg != 8'd0)
                        begin
                            res_valid = 1'b1;
                            res = '{payload_byte: 8'd0, byte_index: count_reg,
                                    frame_status: ST_ABORT, end_of_frame: 1'b1};
                        end
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT, PH_SYNC1, PH_SYNC2, PH_SYNC3, PH_TOKEN:
                    begin
                        if (phase_reg == PH_SYNC1 && item.rx_byte == SYNC1)
                            phase_next = PH_SYNC2;
                        else if (phase_reg == PH_SYNC2 && item.rx_byte == SYNC2)
                            phase_next = PH_SYNC3;
                        else if (phase_reg == PH_SYNC3 && item.rx_byte == SYNC3)
                            phase_next = PH_LENGTH;
                        else if (phase_reg == PH_TOKEN && item.rx_byte == TOKEN)
                        begin
                            phase_next = PH_PAYLOAD;
                            count_next = 8'd0;
                            xor_next   = HDR_XOR ^ bytes_left_reg;
                        end
                        else
                        begin
                            // mismatch: retest this byte as a frame start
                            phase_next = is_sync0 ? PH_SYNC1 : PH_HUNT;
                            if (is_sync0)
                                ticks_next = timeout;
                        end
                    end
                    PH_LENGTH:
                    begin
                        bytes_left_next = item.rx_byte;
                        phase_next      = PH_TOKEN;
                    end
                    PH_PAYLOAD:
                    begin
                        bytes_left_next = left_dec;
                        res_valid       = 1'b1;
                        if (left_dec != 8'd0)
                        begin
                            res = '{payload_byte: item.rx_byte, byte_index: count_reg,
                                    frame_status: ST_PAYLOAD, end_of_frame: 1'b0};
                            count_next = count_reg + 8'd1;
                            xor_next   = xor_reg ^ item.rx_byte;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                            res = '{payload_byte: 8'd0, byte_index: count_reg,
                                    frame_status: (xor_reg == item.rx_byte) ?
                                                  ST_GOOD : ST_BAD,
                                    end_of_frame: 1'b1};
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= 8'd0;
            xor_reg        <= 8'd0;
            count_reg      <= 8'd0;
            ticks_reg      <= 8'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
            count_reg      <= count_next;
            ticks_reg      <= ticks_next;
        end
    end

`ifndef ASSERT_OFF
    a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.end_of_frame |=> phase_reg == PH_HUNT)
        else $error("frame end did not return parser to hunt");

    a_payload_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.frame_status == ST_PAYLOAD
        |=> count_reg == $past(res.byte_index) + 8'd1)
        else $error("payload index did not advance");

    a_tick_only_aborts: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.item_kind == KIND_TICK && res_valid
        |-> res.frame_status == ST_ABORT && $past(phase_reg) != PH_HUNT
            || res.frame_status == ST_ABORT && phase_reg == PH_PAYLOAD)
        else $error("tick produced a non-abort result");
`endif

endmodule

@@ tb/tb_sync_length_xor_deframer_core.sv @@
`timescale 1ns / 1ps
// Testbench for the sync/length/XOR deframer: directed and random frames checked against a predictor.
module tb_sync_length_xor_deframer_core;
    import sld_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 6;

    logic clk;
    logic rst_n;

    sld_item_if   item_ch ();
    sld_result_if res_ch ();
    sld_cfg_if    cfg_ch ();

    sync_length_xor_deframer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // predictor state
    phase_t     ph;
    logic [7:0] len_left;
    logic [7:0] frame_xor;
    logic [7:0] payload_cnt;
    logic [7:0] ticks_left;
    logic [7:0] timeout_reg;

    result_t pending_results[$];
    int      error_count;
    int      mismatch_count;
    int      items_sent;
    int      src_idle_pct;
    int      snk_stall_pct;
    int      hold_cycles;
    int      quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void hunt_for_sync(input logic [7:0] b);
        ph = PH_HUNT;
        if (b == SYNC0)
        begin
            ph = PH_SYNC1;
            ticks_left = timeout_reg;
        end
    endfunction

    function automatic bit deframe_step(input logic kind, input logic [7:0] b,
                                        output result_t r);
        bit emit;
        emit = 1'b0;
        r = '0;
        if (kind == KIND_TICK)
        begin
            if (ph == PH_HUNT)
                return 1'b0;
            if (ticks_left > 8'd1)
            begin
                ticks_left = ticks_left - 8'd1;
                return 1'b0;
            end
            ticks_left = 8'd0;
            emit = (ph == PH_PAYLOAD) && (payload_cnt != 8'd0);
            ph = PH_HUNT;
            if (emit)
            begin
                r.payload_byte = 8'd0;
                r.byte_index   = payload_cnt;
                r.frame_status = ST_ABORT;
                r.end_of_frame = 1'b1;
            end
            return emit;
        end
        case (ph)
            PH_HUNT:
                hunt_for_sync(b);
            PH_SYNC1:
                if (b == SYNC1) ph = PH_SYNC2; else hunt_for_sync(b);
            PH_SYNC2:
                if (b == SYNC2) ph = PH_SYNC3; else hunt_for_sync(b);
            PH_SYNC3:
                if (b == SYNC3) ph = PH_LENGTH; else hunt_for_sync(b);
            PH_LENGTH:
            begin
                len_left = b;
                ph = PH_TOKEN;
            end
            PH_TOKEN:
                if (b == TOKEN)
                begin
                    ph = PH_PAYLOAD;
                    payload_cnt = 8'd0;
                    frame_xor = HDR_XOR ^ len_left;
                end
                else
                    hunt_for_sync(b);
            PH_PAYLOAD:
            begin
                len_left = len_left - 8'd1;
                emit = 1'b1;
                if (len_left != 8'd0)
                begin
                    r.payload_byte = b;
                    r.byte_index   = payload_cnt;
                    r.frame_status = ST_PAYLOAD;
                    r.end_of_frame = 1'b0;
                    payload_cnt = payload_cnt + 8'd1;
                    frame_xor = frame_xor ^ b;
                end
                else
                begin
                    ph = PH_HUNT;
                    r.payload_byte = 8'd0;
                    r.byte_index   = payload_cnt;
                    r.frame_status = (frame_xor == b) ? ST_GOOD : ST_BAD;
                    r.end_of_frame = 1'b1;
                end
            end
            default:
                ph = PH_HUNT;
        endcase
        return emit;
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] data);
        result_t r;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.item_kind <= kind;
        item_ch.rx_byte   <= data;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
        if (deframe_step(kind, data, r))
            pending_results.push_back(r);
    endtask

    task automatic wait_results_done();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [7:0] value);
        wait_results_done();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        timeout_reg = value;
    endtask

    // len 0 wraps to 255 payload bytes; cut_at < 0 sends the whole frame;
    // bad_pos >= 0 replaces that byte with a random one
    task automatic send_frame(input logic [7:0] len, input bit bad_cks, input int cut_at,
                              input int bad_pos, input int tick_pct);
        logic [7:0] frame_q[$];
        logic [7:0] cks;
        logic [7:0] b;
        int         n_payload;
        frame_q = '{SYNC0, SYNC1, SYNC2, SYNC3, len, TOKEN};
        cks = HDR_XOR ^ len;
        n_payload = (len == 8'd0) ? 255 : int'(len) - 1;
        for (int i = 0; i < n_payload; i++)
        begin
            b = 8'($urandom);
            frame_q.push_back(b);
            cks = cks ^ b;
        end
        if (bad_cks)
            cks = cks ^ 8'($urandom_range(1, 255));
        frame_q.push_back(cks);
        for (int i = 0; i < frame_q.size(); i++)
        begin
            if (cut_at >= 0 && i >= cut_at)
                break;
            if (i == bad_pos)
                frame_q[i] = 8'($urandom);
            while ($urandom_range(0, 99) < tick_pct)
                send_item(KIND_TICK, 8'($urandom));
            send_item(KIND_BYTE, frame_q[i]);
        end
    endtask

    task automatic test_directed_frames();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        // tick while hunting
        send_item(KIND_TICK, 8'hFF);
        // good frame with payload extremes
        send_item(KIND_BYTE, SYNC0);
        send_item(KIND_BYTE, SYNC1);
        send_item(KIND_BYTE, SYNC2);
        send_item(KIND_BYTE, SYNC3);
        send_item(KIND_BYTE, 8'd3);
        send_item(KIND_BYTE, TOKEN);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, HDR_XOR ^ 8'd3 ^ 8'hFF);
        // sync broken by a 'U' that starts a new frame
        send_item(KIND_BYTE, SYNC0);
        send_item(KIND_BYTE, SYNC1);
        send_item(KIND_BYTE, SYNC0);
        send_item(KIND_BYTE, SYNC1);
        send_item(KIND_BYTE, SYNC2);
        send_item(KIND_BYTE, SYNC3);
        send_item(KIND_BYTE, 8'd2);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, TOKEN);
        send_item(KIND_BYTE, 8'hA5);
        send_item(KIND_BYTE, HDR_XOR ^ 8'd2 ^ 8'hA5);
        // checksum-only frames, good and bad; token slot holding a 'U'
        send_frame(8'd1, 1'b0, -1, -1, 0);
        send_frame(8'd1, 1'b1, -1, -1, 0);
        send_frame(8'd4, 1'b0, 6, -1, 0);
        send_item(KIND_BYTE, 8'hFF);
        send_frame(8'd3, 1'b0, 5, -1, 0);
        send_frame(8'd2, 1'b1, -1, -1, 0);
    endtask

    task automatic test_timeouts();
        set_timeout(8'd2);
        // expiry before payload is silent
        send_frame(8'd5, 1'b0, 3, -1, 0);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'h00);
        // expiry after payload aborts
        send_frame(8'd5, 1'b0, 8, -1, 0);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'hFF);
        // a new 'U' reloads the count
        send_item(KIND_BYTE, SYNC0);
        send_item(KIND_TICK, 8'h00);
        send_frame(8'd3, 1'b0, -1, -1, 0);
        send_item(KIND_TICK, 8'h00);
        set_timeout(8'd0);
        send_frame(8'd4, 1'b0, 7, -1, 0);
        send_item(KIND_TICK, 8'h00);
        send_frame(8'd2, 1'b0, 6, -1, 0);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, 8'h00);
        set_timeout(8'd1);
        send_frame(8'd6, 1'b0, 9, -1, 0);
        send_item(KIND_TICK, 8'h00);
        set_timeout(8'd255);
        send_frame(8'd6, 1'b0, -1, -1, 40);
    endtask

    task automatic test_long_frames();
        set_timeout(8'd255);
        send_frame(8'd0, 1'b0, -1, -1, 0);
        send_frame(8'd255, 1'b1, -1, -1, 0);
    endtask

    task automatic test_backpressure();
        wait_results_done();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_cycles   = 300;
        send_frame(8'd20, 1'b0, -1, -1, 0);
        send_frame(8'd20, 1'b1, -1, -1, 0);
        wait_results_done();
        send_frame(8'd8, 1'b0, -1, -1, 0);
    endtask

    task automatic test_random(input int src_pct, input int snk_pct,
                               input logic [7:0] timeout, input int n_items);
        int         goal;
        int         pick;
        logic [7:0] len;
        set_timeout(timeout);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 99) == 0)
                    len = $urandom_range(0, 1) ? 8'd0 : 8'd255;
                else
                    len = 8'($urandom_range(1, 12));
                send_frame(len, $urandom_range(0, 3) == 0, -1, -1, 3);
            end
            else if (pick < 85)
                send_frame(8'($urandom_range(1, 12)), 1'b0, $urandom_range(0, 8),
                           $urandom_range(0, 1) ? int'($urandom_range(0, 5)) : -1, 3);
            else
                repeat ($urandom_range(1, 8))
                    send_item(1'($urandom_range(0, 1)), 8'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            res_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (res_ch.valid && res_ch.ready)
        begin
            got.payload_byte = res_ch.payload_byte;
            got.byte_index   = res_ch.byte_index;
            got.frame_status = status_t'(res_ch.frame_status);
            got.end_of_frame = res_ch.end_of_frame;
            if (pending_results.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result byte=%h idx=%0d status=%0d eof=%b",
                             $realtime, got.payload_byte, got.byte_index,
                             got.frame_status, got.end_of_frame);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.payload_byte !== want.payload_byte
                    || got.byte_index !== want.byte_index
                    || got.frame_status !== want.frame_status
                    || got.end_of_frame !== want.end_of_frame)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch exp byte=%h idx=%0d status=%0d eof=%b, %s%h %s%0d %s%0d %s%b",
                                 $realtime, want.payload_byte, want.byte_index,
                                 want.frame_status, want.end_of_frame,
                                 "got byte=", got.payload_byte, "idx=", got.byte_index,
                                 "status=", got.frame_status, "eof=", got.end_of_frame);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $realtime, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.item_kind = KIND_BYTE;
        item_ch.rx_byte   = 8'd0;
        res_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = 8'd0;
        error_count       = 0;
        mismatch_count    = 0;
        items_sent        = 0;
        src_idle_pct      = 0;
        snk_stall_pct     = 0;
        hold_cycles       = 0;
        quiet_cycles      = 0;
        ph                = PH_HUNT;
        len_left          = 8'd0;
        frame_xor         = 8'd0;
        payload_cnt       = 8'd0;
        ticks_left        = 8'd0;
        timeout_reg       = TIMEOUT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_timeouts();
        test_long_frames();
        test_backpressure();
        test_random(0, 0, 8'd1, 300);
        test_random(74, 0, 8'($urandom_range(2, 40)), 300);
        test_random(0, 74, 8'd255, 300);
        test_random(27, 27, 8'd3, 300);

        wait_results_done();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
design/sld_pkg.sv
design/sld_item_if.sv
design/sld_result_if.sv
design/sld_cfg_if.sv
design/sld_parser.sv
design/sync_length_xor_deframer_core.sv
tb/tb_sync_length_xor_deframer_core.sv
